[rtl/gmd_pkg.sv]
// Shared constants and types for the grid maze depth-first solver.
// No dependencies; imported by gmd_flood and grid_maze_dfs_solver.
package gmd_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int NCELLS   = MAX_ROWS * MAX_COLS;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int CELL_W   = ROW_W + COL_W;
  localparam int CFG_W    = 4;
  localparam int LEN_W    = 7;

  typedef struct packed {
    logic hit;   // target cell reached by the fill
    logic dead;  // fill stopped growing, whether or not it reached the target
  } gmd_flood_st_t;

endpackage

[rtl/grid_maze_dfs_solver.sv]
// Top level of the grid maze depth-first solver: sequencer, maze bitmap,
// path stack memory and APB-style configuration port. Uses gmd_pkg, gmd_flood.
//
// Usage: the in_ channel carries one beat per command. mode 0 writes one
// cell of the 8x8 maze bitmap and leaves the sequencer idle. mode 1 searches a
// path from cell (0,0) to the exit (rows_in_use-1, cols_in_use-1); up, left,
// right, down are tried in that order and a neighbor is entered only if the
// flood-fill unit finds the exit still reachable from it off the path.
// The out_ channel returns one beat per path cell, start to exit, with
// out_last on the exit cell; with no path a single beat has found clear.
// The flood-fill unit runs at most four floods per path cell, one for each
// open neighbor tried. Each result beat passes through the stack read, load
// and send states. in_ready is high only while the sequencer is idle.
// A stalled receiver holds the current result beat; no new input beat is
// accepted until the last result beat is taken. Reset makes every cell a wall
// and sets both grid size registers to 8; the path stack needs no clearing.
module grid_maze_dfs_solver import gmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [ROW_W-1:0]  in_cell_row,
  input  logic [COL_W-1:0]  in_cell_col,
  input  logic              in_cell_open,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [ROW_W-1:0]  out_step_row,
  output logic [COL_W-1:0]  out_step_col,
  output logic              out_last,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TOP   = 3'd1;
  localparam logic [2:0] S_NBR   = 3'd2;
  localparam logic [2:0] S_FLOOD = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_SEND  = 3'd6;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic REG_ROWS   = 1'b0;
  localparam logic REG_COLS   = 1'b1;

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  rows_r, rows_nxt;
  logic [CFG_W-1:0]  cols_r, cols_nxt;
  logic [NCELLS-1:0] open_r, open_nxt;
  logic [NCELLS-1:0] path_r, path_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CELL_W-1:0] cur_r, cur_nxt;
  logic [CELL_W-1:0] nb_r, nb_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [ROW_W-1:0]  exr_r, exr_nxt;
  logic [COL_W-1:0]  exc_r, exc_nxt;
  logic [CELL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CELL_W-1:0] stk_mem [NCELLS];
  logic [CELL_W-1:0] stk_rd_r;
  logic              stk_we;
  logic [CELL_W-1:0] stk_wa;
  logic [CELL_W-1:0] stk_wd;

  logic [NCELLS-1:0] inb;
  logic [NCELLS-1:0] allowed;
  logic              cfg_wr;
  logic [ROW_W-1:0]  cr;
  logic [COL_W-1:0]  cc;
  logic [CELL_W-1:0] nb_cell;
  logic              nb_inb;
  logic              nb_ok;
  logic              flood_load;
  gmd_flood_st_t     flood_st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_COLS) ? {28'd0, cols_r} : {28'd0, rows_r};

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_step_row = out_row_r;
  assign out_step_col = out_col_r;
  assign out_last     = out_last_r;

  always_comb begin
    logic [CELL_W-1:0] ci;
    for (int i = 0; i < NCELLS; i++) begin
      ci     = CELL_W'(i);
      inb[i] = (ci[CELL_W-1:COL_W] <= exr_r) && (ci[COL_W-1:0] <= exc_r);
    end
  end

  assign allowed = open_r & ~path_r & inb;
  assign cr      = cur_r[CELL_W-1:COL_W];
  assign cc      = cur_r[COL_W-1:0];

  always_comb begin
    case (dir_r)
      DIR_UP: begin
        nb_inb  = (cr != '0);
        nb_cell = {cr - ROW_W'(1), cc};
      end
      DIR_LEFT: begin
        nb_inb  = (cc != '0);
        nb_cell = {cr, cc - COL_W'(1)};
      end
      DIR_RIGHT: begin
        nb_inb  = (cc < exc_r);
        nb_cell = {cr, cc + COL_W'(1)};
      end
      DIR_DOWN: begin
        nb_inb  = (cr < exr_r);
        nb_cell = {cr + ROW_W'(1), cc};
      end
      default: begin
        nb_inb  = 1'b0;
        nb_cell = cur_r;
      end
    endcase
    nb_ok = nb_inb && open_r[nb_cell] && !path_r[nb_cell];
  end

  gmd_flood u_flood (
    .clk     (clk),
    .load    (flood_load),
    .seed    (nb_cell),
    .allowed (allowed),
    .target  ({exr_r, exc_r}),
    .status  (flood_st)
  );

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    open_nxt      = open_r;
    path_nxt      = path_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    nb_nxt        = nb_r;
    dir_nxt       = dir_r;
    exr_nxt       = exr_r;
    exc_nxt       = exc_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    stk_we        = 1'b0;
    stk_wa        = len_r[CELL_W-1:0];
    stk_wd        = nb_r;
    flood_load    = 1'b0;

    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROWS) begin
        rows_nxt = cfg_pwdata[CFG_W-1:0];
      end else begin
        cols_nxt = cfg_pwdata[CFG_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_WRITE) begin
            open_nxt[{in_cell_row, in_cell_col}] = in_cell_open;
          end else begin
            if (rows_r == '0) begin
              exr_nxt = '0;
            end else if (rows_r > CFG_W'(MAX_ROWS)) begin
              exr_nxt = ROW_W'(MAX_ROWS - 1);
            end else begin
              exr_nxt = ROW_W'(rows_r - CFG_W'(1));
            end
            if (cols_r == '0) begin
              exc_nxt = '0;
            end else if (cols_r > CFG_W'(MAX_COLS)) begin
              exc_nxt = COL_W'(MAX_COLS - 1);
            end else begin
              exc_nxt = COL_W'(cols_r - CFG_W'(1));
            end
            path_nxt  = NCELLS'(1);
            len_nxt   = LEN_W'(1);
            cur_nxt   = '0;
            stk_we    = 1'b1;
            stk_wa    = '0;
            stk_wd    = '0;
            state_nxt = S_TOP;
          end
        end
      end
      S_TOP: begin
        if (cur_r == {exr_r, exc_r}) begin
          rd_idx_nxt = '0;
          state_nxt  = S_RD;
        end else begin
          dir_nxt   = DIR_UP;
          state_nxt = S_NBR;
        end
      end
      S_NBR: begin
        if (nb_ok) begin
          flood_load = 1'b1;
          nb_nxt     = nb_cell;
          state_nxt  = S_FLOOD;
        end else if (dir_r == DIR_DOWN) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_row_nxt   = '0;
          out_col_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_SEND;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      S_FLOOD: begin
        if (flood_st.hit) begin
          stk_we           = 1'b1;
          path_nxt[nb_r]   = 1'b1;
          len_nxt          = len_r + LEN_W'(1);
          cur_nxt          = nb_r;
          state_nxt        = S_TOP;
        end else if (flood_st.dead) begin
          if (dir_r == DIR_DOWN) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_row_nxt   = '0;
            out_col_nxt   = '0;
            out_last_nxt  = 1'b1;
            state_nxt     = S_SEND;
          end else begin
            dir_nxt   = dir_r + 2'd1;
            state_nxt = S_NBR;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_row_nxt   = stk_rd_r[CELL_W-1:COL_W];
        out_col_nxt   = stk_rd_r[COL_W-1:0];
        out_last_nxt  = (({1'b0, rd_idx_r}) + LEN_W'(1) == len_r);
        state_nxt     = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + CELL_W'(1);
            state_nxt  = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= CFG_W'(MAX_ROWS);
      cols_r      <= CFG_W'(MAX_COLS);
      open_r      <= '0;
      path_r      <= '0;
      len_r       <= '0;
      cur_r       <= '0;
      dir_r       <= DIR_UP;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      open_r      <= open_nxt;
      path_r      <= path_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      dir_r       <= dir_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nb_r        <= nb_nxt;
    exr_r       <= exr_nxt;
    exc_r       <= exc_nxt;
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_path_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(path_r) == int'(len_r))
    else $error("path bitmap and path length disagree");

  a_cur_on_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> path_r[cur_r])
    else $error("current cell missing from path bitmap");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result beat is pending");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last)
    else $error("no-path beat without last");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLOOD && flood_st.hit) |=> (len_r == $past(len_r) + LEN_W'(1)))
    else $error("push did not extend the path");

endmodule

[rtl/gmd_flood.sv]
// Iterative flood-fill unit: grows a reach set by one cell step per cycle.
// Depends on gmd_pkg for grid geometry and the status struct.
module gmd_flood import gmd_pkg::*; (
  input  logic                clk,
  input  logic                load,
  input  logic [CELL_W-1:0]   seed,
  input  logic [NCELLS-1:0]   allowed,
  input  logic [CELL_W-1:0]   target,
  output gmd_flood_st_t       status
);

  logic [NCELLS-1:0] reach_r;
  logic [NCELLS-1:0] reach_nxt;
  logic [NCELLS-1:0] grown;
  logic [NCELLS-1:0] col_first;
  logic [NCELLS-1:0] col_last;

  always_comb begin
    for (int i = 0; i < NCELLS; i++) begin
      col_first[i] = ((i % MAX_COLS) == 0);
      col_last[i]  = ((i % MAX_COLS) == (MAX_COLS - 1));
    end
  end

  always_comb begin
    grown = (reach_r >> MAX_COLS) | (reach_r << MAX_COLS)
          | ((reach_r << 1) & ~col_first) | ((reach_r >> 1) & ~col_last);
    reach_nxt = reach_r | (grown & allowed);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reach_r <= NCELLS'(1) << seed;
    end else begin
      reach_r <= reach_nxt;
    end
  end

  assign status.hit  = reach_r[target];
  assign status.dead = (reach_nxt == reach_r);

endmodule

[tb/sv/gmd_tb_pkg.sv]
`timescale 1ns / 100ps
// Testbench-side codes for the grid maze solver: command modes, register
// addresses and the grid size clamp. Depends on gmd_pkg only.
package gmd_tb_pkg;
  import gmd_pkg::*;

  typedef enum logic {
    MODE_WRITE_CELL = 1'b0,
    MODE_SEARCH     = 1'b1
  } gmd_mode_e;

  typedef enum logic [2:0] {
    ADDR_ROWS = 3'd0,
    ADDR_COLS = 3'd4
  } gmd_reg_addr_e;

  function automatic int clamp_span(logic [CFG_W-1:0] value, int limit);
    if (value < 1) return 1;
    if (value > limit) return limit;
    return int'(value);
  endfunction

endpackage

[tb/sv/grid_maze_dfs_solver_checker.sv]
`timescale 1ns / 100ps
// Path checker for the grid maze solver: mirrors the cell bitmap and grid size
// registers from observed beats, predicts each search path and compares results.
// Depends on gmd_pkg and gmd_tb_pkg.
module grid_maze_dfs_solver_checker import gmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_mode,
  input  logic [ROW_W-1:0] in_cell_row,
  input  logic [COL_W-1:0] in_cell_col,
  input  logic             in_cell_open,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_found,
  input  logic [ROW_W-1:0] out_step_row,
  input  logic [COL_W-1:0] out_step_col,
  input  logic             out_last,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  input  logic             cfg_pready,
  output int               mismatches,
  output int               pending,
  output int               beats_seen
);
  import gmd_tb_pkg::*;

  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } path_step_t;

  typedef enum int {DIR_UP, DIR_LEFT, DIR_RIGHT, DIR_DOWN} move_dir_e;

  path_step_t       expected_steps[$];
  logic [NCELLS-1:0] corridor;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  int               fail_tally = 0;
  int               beat_tally = 0;

  // flood from one cell through free cells; true if the goal is touched
  function automatic bit exit_reachable_from(int from, int goal, logic [NCELLS-1:0] free);
    logic [NCELLS-1:0] reach;
    logic [NCELLS-1:0] grown;
    logic [NCELLS-1:0] first_col;
    logic [NCELLS-1:0] last_col;
    first_col = '0;
    last_col  = '0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      first_col[r * MAX_COLS] = 1'b1;
      last_col[r * MAX_COLS + MAX_COLS - 1] = 1'b1;
    end
    reach = '0;
    reach[from] = 1'b1;
    do begin
      grown = reach;
      reach = grown | (((grown >> MAX_COLS) | (grown << MAX_COLS) |
                        ((grown >> 1) & ~last_col) | ((grown << 1) & ~first_col)) & free);
    end while (reach != grown);
    return reach[goal];
  endfunction

  function automatic void predict_search();
    int nr, nc, goal, len, cur, r, c, nb;
    int trail[NCELLS];
    logic [NCELLS-1:0] area;
    logic [NCELLS-1:0] on_path;
    bit reached, moved;
    path_step_t step;
    nr = clamp_span(rows_reg, MAX_ROWS);
    nc = clamp_span(cols_reg, MAX_COLS);
    goal = (nr - 1) * MAX_COLS + nc - 1;
    area = '0;
    for (int ar = 0; ar < nr; ar++) begin
      for (int ac = 0; ac < nc; ac++) begin
        area[ar * MAX_COLS + ac] = 1'b1;
      end
    end
    trail[0] = 0;
    on_path = '0;
    on_path[0] = 1'b1;
    len = 1;
    reached = 1'b0;
    moved = 1'b1;
    while (moved) begin
      cur = trail[len - 1];
      moved = 1'b0;
      if (cur == goal) begin
        reached = 1'b1;
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (!moved && len < NCELLS) begin
            r = cur / MAX_COLS;
            c = cur % MAX_COLS;
            case (move_dir_e'(k))
              DIR_UP:    r--;
              DIR_LEFT:  c--;
              DIR_RIGHT: c++;
              default:   r++;
            endcase
            if (r >= 0 && r < nr && c >= 0 && c < nc) begin
              nb = r * MAX_COLS + c;
              if (corridor[nb] && !on_path[nb] &&
                  exit_reachable_from(nb, goal, corridor & area & ~on_path)) begin
                trail[len] = nb;
                len++;
                on_path[nb] = 1'b1;
                moved = 1'b1;
              end
            end
          end
        end
      end
    end
    if (!reached) begin
      step.found = 1'b0;
      step.row   = '0;
      step.col   = '0;
      step.last  = 1'b1;
      expected_steps.push_back(step);
    end else begin
      for (int i = 0; i < len; i++) begin
        step.found = 1'b1;
        step.row   = ROW_W'(trail[i] / MAX_COLS);
        step.col   = COL_W'(trail[i] % MAX_COLS);
        step.last  = (i == len - 1);
        expected_steps.push_back(step);
      end
    end
  endfunction

  function automatic void check_path_beat();
    path_step_t want;
    beat_tally++;
    if (expected_steps.size() == 0) begin
      fail_tally++;
      $display("%0t: result beat with nothing expected,", $time,
               " got found=%0b row=%0d col=%0d last=%0b",
               out_found, out_step_row, out_step_col, out_last);
    end else begin
      want = expected_steps.pop_front();
      if (want.found !== out_found || want.row !== out_step_row ||
          want.col !== out_step_col || want.last !== out_last) begin
        fail_tally++;
        $display("%0t: expected found=%0b row=%0d col=%0d last=%0b,",
                 $time, want.found, want.row, want.col, want.last,
                 " got found=%0b row=%0d col=%0d last=%0b",
                 out_found, out_step_row, out_step_col, out_last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_steps.delete();
      corridor = '0;
      rows_reg = CFG_W'(MAX_ROWS);
      cols_reg = CFG_W'(MAX_COLS);
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_ROWS) rows_reg = cfg_pwdata[CFG_W-1:0];
        else if (cfg_paddr == ADDR_COLS) cols_reg = cfg_pwdata[CFG_W-1:0];
      end
      if (out_valid && out_ready) check_path_beat();
      if (in_valid && in_ready) begin
        if (in_mode == MODE_SEARCH) predict_search();
        else corridor[int'(in_cell_row) * MAX_COLS + int'(in_cell_col)] = in_cell_open;
      end
    end
    pending    <= expected_steps.size();
    mismatches <= fail_tally;
    beats_seen <= beat_tally;
  end

endmodule

[tb/sv/grid_maze_dfs_solver_test.sv]
`timescale 1ns / 100ps
// Top of the grid maze solver testbench: clock, reset, command beats, register
// writes, receiver back-pressure and the verdict. Depends on gmd_pkg, gmd_tb_pkg,
// grid_maze_dfs_solver and grid_maze_dfs_solver_checker.
module grid_maze_dfs_solver_test;
  import gmd_pkg::*;
  import gmd_tb_pkg::*;

  localparam int TOTAL_ITEMS   = 180;
  localparam int TAIL_ITEMS    = 30;
  localparam int IDLE_LIMIT    = 100000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_mode;
  logic [ROW_W-1:0] in_cell_row;
  logic [COL_W-1:0] in_cell_col;
  logic             in_cell_open;
  logic             out_valid;
  logic             out_ready;
  logic             out_found;
  logic [ROW_W-1:0] out_step_row;
  logic [COL_W-1:0] out_step_col;
  logic             out_last;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [2:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  int fail_count;
  int backlog;
  int beats_checked;
  int items_sent = 0;
  int cell_writes = 0;
  int searches = 0;
  int reg_writes = 0;
  int grid_shapes = 0;
  bit quiet_tail = 1'b0;
  bit send_calm = 1'b0;
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;
  logic [CFG_W-1:0] rows_val;
  logic [CFG_W-1:0] cols_val;

  grid_maze_dfs_solver dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_cell_open (in_cell_open),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_step_row (out_step_row),
    .out_step_col (out_step_col),
    .out_last     (out_last),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  grid_maze_dfs_solver_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_cell_open (in_cell_open),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_step_row (out_step_row),
    .out_step_col (out_step_col),
    .out_last     (out_last),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (fail_count),
    .pending      (backlog),
    .beats_seen   (beats_checked)
  );

  always #10 clk = ~clk;

  task automatic send_beat(input gmd_mode_e mode, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic open_cell);
    int gap;
    if (!quiet_tail && !send_calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_cell_row  <= row;
    in_cell_col  <= col;
    in_cell_open <= open_cell;
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
    if (mode == MODE_SEARCH) searches++;
    else cell_writes++;
    if (items_sent >= TOTAL_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
  endtask

  task automatic search_maze();
    send_beat(MODE_SEARCH, ROW_W'($urandom_range(0, 7)), COL_W'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  // drop valid, wait for every path beat, then let the sequencer settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (backlog != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input gmd_reg_addr_e addr, input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= ($urandom & 32'hFFFF_FFF0) | 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    write_reg(ADDR_ROWS, rows);
    write_reg(ADDR_COLS, cols);
    rows_val = rows;
    cols_val = cols;
    grid_shapes++;
  endtask

  // open a monotone corridor from the start cell to the exit
  task automatic carve_walk(input int nr, input int nc);
    int r, c;
    r = 0;
    c = 0;
    while (r != nr - 1 || c != nc - 1) begin
      if (c == nc - 1 || (r != nr - 1 && $urandom_range(0, 1) == 1)) r++;
      else c++;
      send_beat(MODE_WRITE_CELL, ROW_W'(r), COL_W'(c), 1'b1);
    end
  endtask

  task automatic pick_size(output logic [CFG_W-1:0] value);
    case ($urandom_range(0, 9))
      0: value = 4'd0;
      1: value = CFG_W'($urandom_range(9, 15));
      2: value = 4'd1;
      3: value = 4'd8;
      default: value = CFG_W'($urandom_range(1, 8));
    endcase
  endtask

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : receiver
    int burst;
    int window;
    bit calm;
    out_ready = 1'b0;
    calm = 1'b0;
    window = 0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        window = $urandom_range(50, 300);
        calm = ($urandom_range(0, 2) == 0);
      end
      window--;
      if (want_long_hold && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet_tail && !calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] rows, cols;
    int nr, nc;
    bit first_phase;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_WRITE_CELL;
    in_cell_row  = '0;
    in_cell_col  = '0;
    in_cell_open = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    rows_val     = 4'd8;
    cols_val     = 4'd8;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all walls on the full grid: exit is a wall, no path
    search_maze();
    drain_results();
    // single cell grid: start is the exit even as a wall
    set_grid(4'd1, 4'd1);
    search_maze();
    drain_results();
    // sizes out of range clamp to one row of eight
    set_grid(4'd0, 4'd15);
    for (int c = 1; c < MAX_COLS; c++) send_beat(MODE_WRITE_CELL, 3'd0, COL_W'(c), 1'b1);
    search_maze();
    send_beat(MODE_WRITE_CELL, 3'd0, 3'd4, 1'b0);
    search_maze();
    drain_results();
    set_grid(4'd2, 4'd2);
    send_beat(MODE_WRITE_CELL, 3'd1, 3'd0, 1'b1);
    send_beat(MODE_WRITE_CELL, 3'd1, 3'd1, 1'b1);
    search_maze();
    send_beat(MODE_WRITE_CELL, 3'd7, 3'd7, 1'b1);
    drain_results();
    set_grid(4'd15, 4'd15);
    search_maze();

    first_phase = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      drain_results();
      send_calm = ($urandom_range(0, 3) == 0);
      pick_size(rows);
      pick_size(cols);
      set_grid(rows, cols);
      nr = clamp_span(rows_val, MAX_ROWS);
      nc = clamp_span(cols_val, MAX_COLS);
      repeat ($urandom_range(2, 10)) begin
        if ($urandom_range(0, 5) == 0)
          send_beat(MODE_WRITE_CELL, ROW_W'($urandom_range(0, 7)),
                    COL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        else
          send_beat(MODE_WRITE_CELL, ROW_W'($urandom_range(0, nr - 1)),
                    COL_W'($urandom_range(0, nc - 1)), $urandom_range(0, 9) < 6);
      end
      if ($urandom_range(0, 3) != 0) carve_walk(nr, nc);
      if (first_phase) want_long_hold = 1'b1;
      search_maze();
      repeat ($urandom_range(first_phase ? 1 : 0, 2)) begin
        send_beat(MODE_WRITE_CELL, ROW_W'($urandom_range(0, nr - 1)),
                  COL_W'($urandom_range(0, nc - 1)), 1'($urandom_range(0, 1)));
        search_maze();
      end
      first_phase = 1'b0;
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("Covered %0d cell writes and %0d searches", cell_writes, searches,
             " over %0d grid settings (%0d register writes).", grid_shapes, reg_writes);
    $display("Compared %0d result beats against the predicted paths.", beats_checked);
    if (fail_count == 0 && backlog == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
